// File: src/ecdf_pkg.sv
// ----------------------------------------------------------------------------
// ecdf_pkg
// Shared constants and types for the bivariate ECDF dominance counter.
// ----------------------------------------------------------------------------
package ecdf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int MODE_W     = 2;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int STEP_W     = $clog2(FRAC_W);

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] rem;
    } tok_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHAIN = 3'b010,
        ST_DIV   = 3'b100
    } state_t;

endpackage

// File: src/bivariate_ecdf_dominance_count.sv
// ----------------------------------------------------------------------------
// bivariate_ecdf_dominance_count
// Bivariate empirical CDF over a store of up to MAX_POINTS Q16.16 points.
//
// Command channel: a transaction is taken at a clock edge with start high and
// busy low. mode selects add, query or clear; coord_x/coord_y carry the point.
// Result channel: done is high for one cycle with status, dominated_count,
// cdf_fraction and stored_total; the receiver cannot stall it.
// Add, clear and unused modes: done follows in the next cycle; busy
// stays low, so a command may be taken in every cycle.
// Query: the transaction token walks the chain of MAX_POINTS cells, one cell
// per cycle; on a nonempty store a serial divider then produces 17 quotient
// bits one per cycle. On an empty store done follows the token's exit from
// the chain without the divider; busy is high until done.
// An add to a non-full store shifts every point one cell down the chain, newest in the first cell.
// Reset clears the fill count, the tokens and the result strobe; point
// contents are never read before written.
// ----------------------------------------------------------------------------
module bivariate_ecdf_dominance_count
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ecdf_pkg::MODE_W-1:0]        mode,
    input  logic signed [ecdf_pkg::COORD_W-1:0] coord_x,
    input  logic signed [ecdf_pkg::COORD_W-1:0] coord_y,
    output logic                               done,
    output logic                               status,
    output logic [ecdf_pkg::CNT_W-1:0]         dominated_count,
    output logic [ecdf_pkg::FRAC_W-1:0]        cdf_fraction,
    output logic [ecdf_pkg::CNT_W-1:0]         stored_total
);
    import ecdf_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    point_t            qry_reg;
    point_t            qry_next;
    tok_t              inj_reg;
    tok_t              inj_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic              done_next;
    logic              status_reg;
    logic              status_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [FRAC_W-1:0] frac_next;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  total_next;

    logic              accept;
    logic              full;
    logic              shift_en;
    logic              div_start;
    logic              div_done;
    logic [FRAC_W-1:0] div_quo;
    point_t            new_pt;
    point_t            pt_chain  [0:MAX_POINTS-1];
    tok_t              tok_chain [0:MAX_POINTS];

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign full     = (fill_reg == CNT_W'(MAX_POINTS));
    assign shift_en = accept && (mode == MODE_ADD) && !full;
    assign new_pt.x = coord_x;
    assign new_pt.y = coord_y;
    assign tok_chain[0] = inj_reg;

    genvar i;
    generate
        for (i = 0; i < MAX_POINTS; i++)
        begin : g_cell
            ecdf_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .pt_in    ((i == 0) ? new_pt : pt_chain[(i == 0) ? 0 : i - 1]),
                .pt_out   (pt_chain[i]),
                .qry      (qry_reg),
                .tok_in   (tok_chain[i]),
                .tok_out  (tok_chain[i + 1])
            );
        end
    endgenerate

    ecdf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (tok_chain[MAX_POINTS].cnt),
        .den   (fill_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        qry_next    = qry_reg;
        inj_next    = inj_reg;
        inj_next.vld = 1'b0;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        count_next  = count_reg;
        frac_next   = frac_reg;
        total_next  = total_reg;
        div_start   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = 1'b0;
                    count_next  = '0;
                    frac_next   = '0;
                    total_next  = fill_reg;
                    case (mode)
                        MODE_ADD:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                fill_next  = fill_reg + 1'b1;
                                total_next = fill_reg + 1'b1;
                            end
                        end
                        MODE_QUERY:
                        begin
                            qry_next     = new_pt;
                            inj_next.vld = 1'b1;
                            inj_next.cnt = '0;
                            inj_next.rem = fill_reg;
                            state_next   = ST_CHAIN;
                        end
                        MODE_CLEAR:
                        begin
                            done_next  = 1'b1;
                            fill_next  = '0;
                            total_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CHAIN:
            begin
                if (tok_chain[MAX_POINTS].vld)
                begin
                    cnt_next = tok_chain[MAX_POINTS].cnt;
                    if (fill_reg == '0)
                    begin
                        done_next  = 1'b1;
                        count_next = '0;
                        frac_next  = '0;
                        total_next = fill_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    count_next = cnt_reg;
                    frac_next  = div_quo;
                    total_next = fill_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            inj_reg     <= '0;
            done_reg    <= 1'b0;
            status_reg  <= 1'b0;
            count_reg   <= '0;
            frac_reg    <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            inj_reg     <= inj_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            count_reg   <= count_next;
            frac_reg    <= frac_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qry_reg     <= qry_next;
        cnt_reg     <= cnt_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign dominated_count = count_reg;
    assign cdf_fraction    = frac_reg;
    assign stored_total    = total_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_POINTS))
        else $error("fill count above store size");

    a_tok_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[MAX_POINTS].vld |-> state_reg == ST_CHAIN)
        else $error("query token left chain outside chain state");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> stored_total == CNT_W'(MAX_POINTS))
        else $error("add dropped while store not full");

    a_frac_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dominated_count != '0) |-> cdf_fraction != '0)
        else $error("nonzero count with zero fraction");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_QUERY) |=> busy && !done)
        else $error("query transaction did not hold busy");
`endif

endmodule

// File: src/ecdf_cell.sv
// ----------------------------------------------------------------------------
// ecdf_cell
// One cell of the point chain: holds one point, shifts it on an add, and
// adds its hit to the query transaction token passing through.
// ----------------------------------------------------------------------------
module ecdf_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  ecdf_pkg::point_t pt_in,
    output ecdf_pkg::point_t pt_out,
    input  ecdf_pkg::point_t qry,
    input  ecdf_pkg::tok_t   tok_in,
    output ecdf_pkg::tok_t   tok_out
);
    import ecdf_pkg::*;

    point_t pt_reg;
    point_t pt_next;
    tok_t   tok_reg;
    tok_t   tok_next;
    logic   hit;

    always_comb
    begin
        pt_next = shift_en ? pt_in : pt_reg;
        hit = (tok_in.rem != '0)
              && ($signed(pt_reg.x) <= $signed(qry.x))
              && ($signed(pt_reg.y) <= $signed(qry.y));
        tok_next.vld = tok_in.vld;
        tok_next.cnt = tok_in.cnt + {{(CNT_W-1){1'b0}}, hit};
        tok_next.rem = (tok_in.rem != '0) ? tok_in.rem - 1'b1 : tok_in.rem;
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign pt_out  = pt_reg;
    assign tok_out = tok_reg;

endmodule

// File: src/ecdf_div.sv
// ----------------------------------------------------------------------------
// ecdf_div
// Restoring divider: floor(num * 2^16 / den) for num <= den, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module ecdf_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ecdf_pkg::CNT_W-1:0]  num,
    input  logic [ecdf_pkg::CNT_W-1:0]  den,
    output logic                        done,
    output logic [ecdf_pkg::FRAC_W-1:0] quo
);
    import ecdf_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W:0]    rem_next;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W-1:0]  den_next;
    logic [FRAC_W-1:0] quo_reg;
    logic [FRAC_W-1:0] quo_next;
    logic              ge;
    logic [CNT_W:0]    diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        ge   = rem_reg >= {1'b0, den_reg};
        diff = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, num};
            den_next  = den;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[FRAC_W-2:0], ge};
            rem_next  = {diff[CNT_W-1:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
